@@ src/fsbc_pkg.sv @@
// shared types and constants for the figurate sum block counter
package fsbc_pkg;

  typedef enum logic [1:0] {
    KIND_SQUARE   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_PRONIC   = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_NUMBER_KIND = 1'b0,
    CFG_PAIR_MODE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_OUTER_MUL,
    ST_OUTER_CHK,
    ST_ROOT_GO,
    ST_ROOT,
    ST_FIX_MUL,
    ST_FIX_CHK,
    ST_INNER_MUL,
    ST_INNER_CHK,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DRAIN_RD,
    ST_DRAIN_LD,
    ST_DRAIN_WAIT
  } state_e;

endpackage

@@ src/fsbc_if.sv @@
// valid/ready channel interfaces for commands and results
interface fsbc_cmd_if #(
  parameter int unsigned START_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [START_BITS-1:0] window_start;
  logic [6:0]            window_length;
  modport source (output valid, window_start, window_length, input ready);
  modport sink   (input valid, window_start, window_length, output ready);
endinterface

interface fsbc_res_if #(
  parameter int unsigned COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] coefficient;
  logic [5:0]            offset;
  logic                  last;
  modport source (output valid, coefficient, offset, last, input ready);
  modport sink   (input valid, coefficient, offset, last, output ready);
endinterface

@@ src/fsbc_isqrt.sv @@
// multicycle integer square root, one result bit per step
module fsbc_isqrt #(
  parameter int unsigned W = 36
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   value_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int unsigned HW = W / 2;
  localparam int unsigned SW = $clog2(HW + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  res_q, res_d;
  logic [W-1:0]  bit_q, bit_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    if (start_i) begin
      rem_d  = value_i;
      res_d  = '0;
      bit_d  = {2'b01, {(W-2){1'b0}}};
      busy_d = 1'b1;
      cnt_d  = SW'(HW);
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // done pulses the cycle after the last step
  assign done_o = done_q;
  assign root_o = res_q[HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      rem_q  <= rem_d;
      res_q  <= res_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

@@ src/fsbc_acc_ram.sv @@
// accumulator memory, one write and one registered read port
module fsbc_acc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);
  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/figurate_sum_block_counter.sv @@
// figurate sum block counter: series sweep into an accumulator memory, one command at a time
// flow: the command is accepted, a clear pass over all WINDOW_MAX words, the sweep, then the drain
// pair mode: per outer term a multiply and check, one root, an index fix-up, then the inner
// sweep with a read-modify-write per hit; single mode runs one root, then the inner sweep
// a new command is taken after the last transfer; each result is read, loaded, then held until taken
// reset: number_kind squares, pair_mode on, no command in flight
module figurate_sum_block_counter
  import fsbc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned START_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [1:0] cfg_data_i,
  fsbc_cmd_if.sink   cmd,
  fsbc_res_if.source res
);
  localparam int unsigned AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LW  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned TW  = START_BITS + 1;            // window end
  localparam int unsigned RW  = START_BITS + 4;            // root operand
  localparam int unsigned RWE = RW + (RW % 2);
  localparam int unsigned KW  = RWE / 2;                   // series index
  localparam int unsigned PW  = 2 * KW;                    // series member

  kind_e kind_q;
  logic  pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_SQUARE;
      pair_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NUMBER_KIND: kind_q <= kind_e'(cfg_data_i);
        CFG_PAIR_MODE:   pair_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e                state_q, state_d;
  kind_e                 ekind_q, ekind_d;
  logic                  pmode_q, pmode_d;
  logic [START_BITS-1:0] start_q, start_d;
  logic [TW-1:0]         end_q, end_d;
  logic [LW-1:0]         len_q, len_d;
  logic [LW-1:0]         ptr_q, ptr_d;
  logic [KW-1:0]         ko_q, ko_d;       // outer index
  logic [KW-1:0]         kj_q, kj_d;       // inner index
  logic [PW-1:0]         x_q, x_d;         // outer term
  logic [AW-1:0]         addr_q, addr_d;
  logic [2:0]            wgt_q, wgt_d;
  logic                  ovalid_q, ovalid_d;
  logic [COUNT_BITS-1:0] ocoef_q, ocoef_d;
  logic [5:0]            ooff_q, ooff_d;
  logic                  olast_q, olast_d;
  logic [PW-1:0]         prod_q;

  // one multiplier, product registered
  logic [KW-1:0]   mul_k;
  logic [KW:0]     mul_a, mul_b;
  logic [2*KW+1:0] mul_p;
  logic [PW-1:0]   term_d;

  always_comb begin
    mul_k  = (state_q == ST_OUTER_MUL) ? ko_q : kj_q;
    mul_a  = {1'b0, mul_k};
    mul_b  = (ekind_q == KIND_SQUARE) ? mul_a : mul_a + (KW+1)'(1);
    mul_p  = mul_a * mul_b;
    term_d = (ekind_q == KIND_TRIANGLE) ? mul_p[PW:1] : mul_p[PW-1:0];
  end

  // integer root unit
  logic                  sq_start;
  logic                  sq_done;
  logic [RWE-1:0]        sq_val;
  logic [KW-1:0]         sq_root;
  logic [KW-1:0]         root_k;
  logic [START_BITS-1:0] m_val;

  fsbc_isqrt #(.W(RWE)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // lowest series member still able to reach the window
  assign m_val = (PW'(start_q) > x_q) ? START_BITS'(PW'(start_q) - x_q) : '0;

  always_comb begin
    case (ekind_q)
      KIND_TRIANGLE: sq_val = RWE'({m_val, 3'b000}) + RWE'(1);
      KIND_PRONIC:   sq_val = RWE'({m_val, 2'b00}) + RWE'(1);
      default:       sq_val = RWE'(m_val);
    endcase
  end

  always_comb begin
    case (ekind_q)
      KIND_TRIANGLE, KIND_PRONIC: root_k = (sq_root - KW'(1)) >> 1;
      default:                    root_k = sq_root;
    endcase
  end

  // accumulator memory
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
  logic [COUNT_BITS:0]   sat_sum;
  logic [PW:0]           hit_sum, hit_off;
  logic                  wo2, wi2;

  fsbc_acc_ram #(.DEPTH(WINDOW_MAX), .DW(COUNT_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign hit_sum = {1'b0, x_q} + {1'b0, prod_q};
  assign hit_off = hit_sum - (PW+1)'(start_q);
  assign sat_sum = {1'b0, mem_rdata} + (COUNT_BITS+1)'(wgt_q);
  // outer weight only counts in pair mode
  assign wo2 = pmode_q && (ekind_q == KIND_SQUARE) && (ko_q != '0);
  assign wi2 = (ekind_q == KIND_SQUARE) && (kj_q != '0);

  assign res.valid       = ovalid_q;
  assign res.coefficient = ocoef_q;
  assign res.offset      = ooff_q;
  assign res.last        = olast_q;

  always_comb begin
    state_d   = state_q;
    ekind_d   = ekind_q;
    pmode_d   = pmode_q;
    start_d   = start_q;
    end_d     = end_q;
    len_d     = len_q;
    ptr_d     = ptr_q;
    ko_d      = ko_q;
    kj_d      = kj_q;
    x_d       = x_q;
    addr_d    = addr_q;
    wgt_d     = wgt_q;
    ovalid_d  = ovalid_q;
    ocoef_d   = ocoef_q;
    ooff_d    = ooff_q;
    olast_d   = olast_q;
    sq_start  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_raddr = addr_q;
    cmd.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && cmd.window_length != 7'd0) begin
          ekind_d = (kind_q == KIND_UNUSED) ? KIND_SQUARE : kind_q;
          pmode_d = pair_q;
          start_d = cmd.window_start;
          len_d   = (cmd.window_length > 7'(WINDOW_MAX)) ? LW'(WINDOW_MAX)
                                                        : LW'(cmd.window_length);
          end_d   = {1'b0, cmd.window_start} + TW'(len_d);
          ptr_d   = '0;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        ptr_d     = ptr_q + LW'(1);
        if (ptr_q == LW'(WINDOW_MAX - 1)) begin
          ptr_d   = '0;
          ko_d    = '0;
          x_d     = '0;
          state_d = pmode_q ? ST_OUTER_MUL : ST_ROOT_GO;
        end
      end
      ST_OUTER_MUL: begin
        state_d = ST_OUTER_CHK;
      end
      ST_OUTER_CHK: begin
        if (prod_q < PW'(end_q)) begin
          x_d     = prod_q;
          state_d = ST_ROOT_GO;
        end else begin
          state_d = ST_DRAIN_RD;
        end
      end
      ST_ROOT_GO: begin
        sq_start = 1'b1;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          kj_d    = root_k;
          state_d = ST_FIX_MUL;
        end
      end
      ST_FIX_MUL: begin
        state_d = ST_FIX_CHK;
      end
      ST_FIX_CHK: begin
        // step up to the smallest index whose member reaches m
        if (prod_q < PW'(m_val)) begin
          kj_d = kj_q + KW'(1);
        end
        state_d = ST_INNER_MUL;
      end
      ST_INNER_MUL: begin
        state_d = ST_INNER_CHK;
      end
      ST_INNER_CHK: begin
        if (hit_sum < (PW+1)'(end_q)) begin
          addr_d = hit_off[AW-1:0];
          case ({wo2, wi2})
            2'b11:   wgt_d = 3'd4;
            2'b00:   wgt_d = 3'd1;
            default: wgt_d = 3'd2;
          endcase
          state_d = ST_RMW_RD;
        end else if (pmode_q) begin
          ko_d    = ko_q + KW'(1);
          state_d = ST_OUTER_MUL;
        end else begin
          state_d = ST_DRAIN_RD;
        end
      end
      ST_RMW_RD: begin
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sat_sum[COUNT_BITS] ? '1 : sat_sum[COUNT_BITS-1:0];
        kj_d      = kj_q + KW'(1);
        state_d   = ST_INNER_MUL;
      end
      ST_DRAIN_RD: begin
        mem_raddr = ptr_q[AW-1:0];
        state_d   = ST_DRAIN_LD;
      end
      ST_DRAIN_LD: begin
        ovalid_d = 1'b1;
        ocoef_d  = mem_rdata;
        ooff_d   = 6'(ptr_q);
        olast_d  = ((ptr_q + LW'(1)) == len_q);
        state_d  = ST_DRAIN_WAIT;
      end
      ST_DRAIN_WAIT: begin
        if (res.ready) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_q + LW'(1);
            state_d = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ekind_q  <= KIND_SQUARE;
      pmode_q  <= 1'b0;
      start_q  <= '0;
      end_q    <= '0;
      len_q    <= '0;
      ptr_q    <= '0;
      ko_q     <= '0;
      kj_q     <= '0;
      x_q      <= '0;
      addr_q   <= '0;
      wgt_q    <= '0;
      ovalid_q <= 1'b0;
      ocoef_q  <= '0;
      ooff_q   <= '0;
      olast_q  <= 1'b0;
      prod_q   <= '0;
    end else begin
      state_q  <= state_d;
      ekind_q  <= ekind_d;
      pmode_q  <= pmode_d;
      start_q  <= start_d;
      end_q    <= end_d;
      len_q    <= len_d;
      ptr_q    <= ptr_d;
      ko_q     <= ko_d;
      kj_q     <= kj_d;
      x_q      <= x_d;
      addr_q   <= addr_d;
      wgt_q    <= wgt_d;
      ovalid_q <= ovalid_d;
      ocoef_q  <= ocoef_d;
      ooff_q   <= ooff_d;
      olast_q  <= olast_d;
      prod_q   <= term_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.coefficient)
                                && $stable(res.offset) && $stable(res.last))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> state_q == ST_DRAIN_WAIT)
    else $error("result offered outside the drain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ready |-> !res.valid)
    else $error("command taken while a result waits");
endmodule

@@ test/tb.sv @@
// self-checking testbench for the figurate sum block counter
`timescale 1ns / 1ps

module tb
  import fsbc_pkg::*;
();

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [1:0] cfg_data_i = '0;

  fsbc_cmd_if #(.START_BITS(32)) cmd_if ();
  fsbc_res_if #(.COUNT_BITS(16)) res_if ();

  figurate_sum_block_counter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd        (cmd_if),
    .res        (res_if)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] start;
    logic [6:0]  length;
  } window_t;

  typedef struct packed {
    logic [15:0] coefficient;
    logic [5:0]  offset;
    logic        last;
  } coef_t;

  window_t window_q[$];
  coef_t   coef_q[$];

  kind_e model_kind = KIND_SQUARE;
  logic  model_pair = 1'b1;
  logic [15:0] acc_mem[64];

  int  n_errors = 0;
  int  n_windows = 0;
  int  n_coefs = 0;
  bit  quiet = 1'b0;
  int  hold_reqs = 0;
  int  hold_done = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned series_term(kind_e kd, longint unsigned k);
    if (kd == KIND_SQUARE) return k * k;
    if (kd == KIND_TRIANGLE) return (k * (k + 1)) >> 1;
    return k * (k + 1);
  endfunction

  function automatic longint unsigned member_weight(kind_e kd, longint unsigned k);
    return (kd == KIND_SQUARE && k != 0) ? 2 : 1;
  endfunction

  // smallest index whose series member is at least m
  function automatic longint unsigned lowest_index(kind_e kd, longint unsigned m);
    longint unsigned k;
    if (kd == KIND_SQUARE) k = int_root(m);
    else if (kd == KIND_TRIANGLE) k = (int_root((m << 3) + 1) - 1) >> 1;
    else k = (int_root((m << 2) + 1) - 1) >> 1;
    if (series_term(kd, k) < m) k++;
    return k;
  endfunction

  task automatic predict_window(window_t w);
    longint unsigned start, len, stop, k, j, x, y, s;
    kind_e kd;
    coef_t c;
    start = w.start;
    len = w.length;
    kd = (model_kind == KIND_UNUSED) ? KIND_SQUARE : model_kind;
    if (len == 0) return;
    if (len > 64) len = 64;
    stop = start + len;
    foreach (acc_mem[i]) acc_mem[i] = '0;
    if (!model_pair) begin
      for (k = lowest_index(kd, start); series_term(kd, k) < stop; k++) begin
        x = series_term(kd, k);
        acc_mem[(x - start) & 63] = 16'(member_weight(kd, k));
      end
    end else begin
      for (k = 0; series_term(kd, k) < stop; k++) begin
        x = series_term(kd, k);
        j = lowest_index(kd, start > x ? start - x : 0);
        for (; series_term(kd, j) + x < stop; j++) begin
          y = series_term(kd, j);
          s = acc_mem[(x + y - start) & 63] + member_weight(kd, k) * member_weight(kd, j);
          acc_mem[(x + y - start) & 63] = (s > 65535) ? 16'hffff : 16'(s);
        end
      end
    end
    for (int p = 0; p < len; p++) begin
      c.coefficient = acc_mem[p];
      c.offset = 6'(p);
      c.last = (p + 1 == len);
      coef_q.push_back(c);
    end
  endtask

  // command driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.window_start <= '0;
      cmd_if.window_length <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_window('{cmd_if.window_start, cmd_if.window_length});
        n_windows++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          cmd_if.valid <= 1'b0;
        end else if (window_q.size() != 0) begin
          window_t w;
          w = window_q.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.window_start <= w.start;
          cmd_if.window_length <= w.length;
          if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 15);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result sink with random stalls and requested long hold-offs
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_reqs != hold_done && res_if.valid) begin
        hold_done <= hold_done + 1;
        stall_left <= 400;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 15) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      coef_t got, want;
      got = '{res_if.coefficient, res_if.offset, res_if.last};
      n_coefs++;
      if (coef_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual coef %0d offset %0d last %0b", $time,
                 got.coefficient, got.offset, got.last);
        n_errors++;
      end else begin
        want = coef_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected coef %0d offset %0d last %0b, %s",
                   $time, want.coefficient, want.offset, want.last,
                   $sformatf("actual coef %0d offset %0d last %0b",
                             got.coefficient, got.offset, got.last));
          n_errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (window_q.size() != 0 || cmd_if.valid || coef_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUMBER_KIND) model_kind = kind_e'(data);
    else model_pair = data[0];
  endtask

  function automatic window_t random_window(bit pair);
    window_t w;
    if (!pair && $urandom_range(0, 3) == 0) w.start = $urandom;
    else if ($urandom_range(0, 7) == 0) w.start = $urandom_range(0, 1 << 20);
    else w.start = $urandom_range(0, 5000);
    if ($urandom_range(0, 9) == 0) w.length = 7'($urandom_range(0, 127));
    else w.length = 7'($urandom_range(1, 64));
    return w;
  endfunction

  initial begin
    kind_e kinds[4];
    kinds = '{KIND_SQUARE, KIND_TRIANGLE, KIND_PRONIC, KIND_UNUSED};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: squares, pair count
    window_q.push_back('{32'd0, 7'd1});
    window_q.push_back('{32'd0, 7'd64});
    window_q.push_back('{32'd25, 7'd1});
    window_q.push_back('{32'd1 << 20, 7'd64});
    window_q.push_back('{32'd100, 7'd0});
    window_q.push_back('{32'd7, 7'd127});
    window_q.push_back('{32'd300, 7'd65});
    wait_drained();

    // block fills while the sink holds off
    hold_reqs++;
    repeat (6) window_q.push_back(random_window(1'b1));
    wait_drained();

    foreach (kinds[i]) begin
      for (int pm = 0; pm < 2; pm++) begin
        if (i == 3 && pm == 1) quiet = 1'b1;
        write_reg(CFG_NUMBER_KIND, kinds[i]);
        write_reg(CFG_PAIR_MODE, 2'(pm));
        if (pm == 0) begin
          window_q.push_back('{32'hffff_ffff, 7'd64});
          window_q.push_back('{32'hffff_ffc0, 7'd64});
          window_q.push_back('{32'd0, 7'd1});
        end
        repeat (10) window_q.push_back(random_window(pm[0]));
        wait_drained();
      end
    end

    $display("covered %0d windows and %0d coefficients over all kinds, both modes",
             n_windows, n_coefs);
    if (n_errors == 0) $display("figurate_sum_block_counter: match");
    else $display("figurate_sum_block_counter: mismatch");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("figurate_sum_block_counter: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
src/fsbc_pkg.sv
src/fsbc_if.sv
src/fsbc_isqrt.sv
src/fsbc_acc_ram.sv
src/figurate_sum_block_counter.sv
test/tb.sv
